// ----- design/srpc_pkg.sv -----
package srpc_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_SV_SQ,
        ST_SV_TEST,
        ST_SV_CHK,
        ST_SV_MARK,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_LB_STEP,
        ST_LB_CMP,
        ST_LB_CHK,
        ST_UB_STEP,
        ST_UB_CMP,
        ST_UB_CHK,
        ST_DONE
    } state_t;

    localparam int FIELD_BITS = 16;
    localparam int COUNT_BITS = 11;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 11'd2047;

endpackage

// ----- design/srpc_if.sv -----
interface srpc_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            kind;
    logic [srpc_pkg::FIELD_BITS-1:0]       value;
    logic [srpc_pkg::FIELD_BITS-1:0]       range_low;
    logic [srpc_pkg::FIELD_BITS-1:0]       range_high;

    modport source (output valid, kind, value, range_low, range_high, input ready);
    modport sink   (input valid, kind, value, range_low, range_high, output ready);
endinterface

interface srpc_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic [srpc_pkg::COUNT_BITS-1:0]       prime_count;

    modport source (output valid, found, prime_count, input ready);
    modport sink   (input valid, found, prime_count, output ready);
endinterface

// ----- design/sorted_range_prime_counter.sv -----
// load reads the prime bitmap, then writes the table entry; a query runs
// two binary searches, each step one table read and one compare on the single read port
// throughput: one item at a time, the next is taken once the current one is finished
// reset: entry count cleared, then a sieve runs over the prime bitmap: a fill pass, then
// marking passes that strike the composites; no item is taken meanwhile
// each table entry keeps a running prime count, so a range count is one subtraction
module sorted_range_prime_counter #(
    parameter int ENTRIES    = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    srpc_req_if.sink    req,
    srpc_rsp_if.source  rsp
);

    localparam int AW     = $clog2(ENTRIES);
    localparam int IW     = $clog2(ENTRIES + 1);
    localparam int CW     = IW;
    localparam int VB     = VALUE_BITS;
    localparam int MW     = 1 + CW + VB;
    localparam int SPW    = VB + 1;
    localparam int XW     = (VB > srpc_pkg::FIELD_BITS) ? VB : srpc_pkg::FIELD_BITS;
    localparam int SW     = (CW > srpc_pkg::COUNT_BITS) ? CW : srpc_pkg::COUNT_BITS;
    localparam int DEPTH  = 1 << VB;
    localparam logic [SPW-1:0] SPAN = {1'b1, {VB{1'b0}}};

    // table word: {prime bit, primes in entries 0..k inclusive, value}
    logic [MW-1:0] tmem [ENTRIES];
    logic          pmem [DEPTH];

    srpc_pkg::state_t state_reg, state_next;

    logic [IW-1:0]   n_reg, n_next;
    logic [CW-1:0]   tot_reg, tot_next;
    logic [IW-1:0]   lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [IW-1:0]   first_reg, first_next;
    logic [VB-1:0]   val_reg, val_next, ql_reg, ql_next, qh_reg, qh_next;
    logic            fprime_reg, fprime_next;
    logic [CW-1:0]   fincl_reg, fincl_next;
    logic            res_found_reg, res_found_next;
    logic [srpc_pkg::COUNT_BITS-1:0] res_count_reg, res_count_next;
    logic [VB-1:0]   i_reg, i_next, init_reg, init_next;
    logic [SPW-1:0]  j_reg, j_next;
    logic [2*VB-1:0] sq_reg, sq_next;
    logic            ov_reg, ov_next;
    logic            of_reg, of_next;
    logic [srpc_pkg::COUNT_BITS-1:0] oc_reg, oc_next;

    logic [MW-1:0]   trd_reg;
    logic            prd_reg;

    // memory port controls
    logic            t_re, t_we, p_re, p_we, p_wdata;
    logic [AW-1:0]   t_raddr, t_waddr;
    logic [MW-1:0]   t_wdata;
    logic [VB-1:0]   p_raddr, p_waddr;

    // request fields reduced to VALUE_BITS
    logic [XW-1:0]   val_ext, ql_ext, qh_ext;
    logic [IW:0]     mid_sum;
    logic [IW-1:0]   mid_c;
    logic [SPW-1:0]  j_sum;
    logic [VB-1:0]   rd_value;
    logic [CW-1:0]   rd_incl;
    logic            rd_prime;
    logic [CW-1:0]   cnt_c;
    logic [SW-1:0]   cnt_ext;

    assign val_ext  = XW'(req.value);
    assign ql_ext   = XW'(req.range_low);
    assign qh_ext   = XW'(req.range_high);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c    = mid_sum[IW:1];
    assign j_sum    = j_reg + {1'b0, i_reg};
    assign rd_value = trd_reg[VB-1:0];
    assign rd_incl  = trd_reg[VB+CW-1:VB];
    assign rd_prime = trd_reg[MW-1];
    assign cnt_c    = rd_incl - fincl_reg + CW'(fprime_reg);
    assign cnt_ext  = SW'(cnt_c);

    assign req.ready       = (state_reg == srpc_pkg::ST_IDLE);
    assign rsp.valid       = ov_reg;
    assign rsp.found       = of_reg;
    assign rsp.prime_count = oc_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tmem[t_waddr] <= t_wdata;
        end
        if (t_re)
        begin
            trd_reg <= tmem[t_raddr];
        end
        if (p_we)
        begin
            pmem[p_waddr] <= p_wdata;
        end
        if (p_re)
        begin
            prd_reg <= pmem[p_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srpc_pkg::ST_INIT;
            n_reg     <= '0;
            tot_reg   <= '0;
            init_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            tot_reg   <= tot_next;
            init_reg  <= init_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        first_reg     <= first_next;
        val_reg       <= val_next;
        ql_reg        <= ql_next;
        qh_reg        <= qh_next;
        fprime_reg    <= fprime_next;
        fincl_reg     <= fincl_next;
        res_found_reg <= res_found_next;
        res_count_reg <= res_count_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        sq_reg        <= sq_next;
        of_reg        <= of_next;
        oc_reg        <= oc_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        tot_next       = tot_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        first_next     = first_reg;
        val_next       = val_reg;
        ql_next        = ql_reg;
        qh_next        = qh_reg;
        fprime_next    = fprime_reg;
        fincl_next     = fincl_reg;
        res_found_next = res_found_reg;
        res_count_next = res_count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        sq_next        = sq_reg;
        init_next      = init_reg;
        ov_next        = ov_reg && !rsp.ready;
        of_next        = of_reg;
        oc_next        = oc_reg;
        t_re           = 1'b0;
        t_raddr        = mid_c[AW-1:0];
        t_we           = 1'b0;
        t_waddr        = n_reg[AW-1:0];
        t_wdata        = {prd_reg, tot_reg + CW'(prd_reg), val_reg};
        p_re           = 1'b0;
        p_raddr        = i_reg;
        p_we           = 1'b0;
        p_waddr        = init_reg;
        p_wdata        = (init_reg >= VB'(2));

        unique case (state_reg)
            // fill bitmap: everything from 2 up marked prime
            srpc_pkg::ST_INIT:
            begin
                p_we      = 1'b1;
                init_next = init_reg + VB'(1);
                if (init_reg == {VB{1'b1}})
                begin
                    i_next     = VB'(2);
                    state_next = srpc_pkg::ST_SV_SQ;
                end
            end
            srpc_pkg::ST_SV_SQ:
            begin
                sq_next    = i_reg * i_reg;
                state_next = srpc_pkg::ST_SV_TEST;
            end
            srpc_pkg::ST_SV_TEST:
            begin
                if (sq_reg >= (2*VB)'(SPAN))
                begin
                    state_next = srpc_pkg::ST_IDLE;
                end
                else
                begin
                    p_re       = 1'b1;
                    state_next = srpc_pkg::ST_SV_CHK;
                end
            end
            srpc_pkg::ST_SV_CHK:
            begin
                if (prd_reg)
                begin
                    j_next     = SPW'(sq_reg);
                    state_next = srpc_pkg::ST_SV_MARK;
                end
                else
                begin
                    i_next     = i_reg + VB'(1);
                    state_next = srpc_pkg::ST_SV_SQ;
                end
            end
            // strike multiples of i starting at i*i
            srpc_pkg::ST_SV_MARK:
            begin
                p_we    = 1'b1;
                p_waddr = j_reg[VB-1:0];
                p_wdata = 1'b0;
                j_next  = j_sum;
                if (j_sum >= SPAN)
                begin
                    i_next     = i_reg + VB'(1);
                    state_next = srpc_pkg::ST_SV_SQ;
                end
            end
            srpc_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    val_next = val_ext[VB-1:0];
                    ql_next  = ql_ext[VB-1:0];
                    qh_next  = qh_ext[VB-1:0];
                    lo_next  = '0;
                    hi_next  = n_reg;
                    priority case (req.kind)
                        srpc_pkg::KIND_LOAD:
                        begin
                            if (n_reg < IW'(ENTRIES))
                            begin
                                state_next = srpc_pkg::ST_LD_RD;
                            end
                        end
                        srpc_pkg::KIND_QUERY:
                        begin
                            state_next = srpc_pkg::ST_LB_STEP;
                        end
                        srpc_pkg::KIND_CLEAR:
                        begin
                            n_next   = '0;
                            tot_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            srpc_pkg::ST_LD_RD:
            begin
                p_re       = 1'b1;
                p_raddr    = val_reg;
                state_next = srpc_pkg::ST_LD_WR;
            end
            srpc_pkg::ST_LD_WR:
            begin
                t_we       = 1'b1;
                tot_next   = tot_reg + CW'(prd_reg);
                n_next     = n_reg + IW'(1);
                state_next = srpc_pkg::ST_IDLE;
            end
            // lower bound of range_low
            srpc_pkg::ST_LB_STEP:
            begin
                if (lo_reg < hi_reg)
                begin
                    t_re       = 1'b1;
                    mid_next   = mid_c;
                    state_next = srpc_pkg::ST_LB_CMP;
                end
                else if (lo_reg < n_reg)
                begin
                    t_re       = 1'b1;
                    t_raddr    = lo_reg[AW-1:0];
                    first_next = lo_reg;
                    state_next = srpc_pkg::ST_LB_CHK;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_count_next = '0;
                    state_next     = srpc_pkg::ST_DONE;
                end
            end
            srpc_pkg::ST_LB_CMP:
            begin
                if (rd_value >= ql_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + IW'(1);
                end
                state_next = srpc_pkg::ST_LB_STEP;
            end
            srpc_pkg::ST_LB_CHK:
            begin
                fprime_next = rd_prime;
                fincl_next  = rd_incl;
                lo_next     = '0;
                hi_next     = n_reg;
                if (rd_value == ql_reg)
                begin
                    state_next = srpc_pkg::ST_UB_STEP;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_count_next = '0;
                    state_next     = srpc_pkg::ST_DONE;
                end
            end
            // upper bound of range_high
            srpc_pkg::ST_UB_STEP:
            begin
                if (lo_reg < hi_reg)
                begin
                    t_re       = 1'b1;
                    mid_next   = mid_c;
                    state_next = srpc_pkg::ST_UB_CMP;
                end
                else if (lo_reg != '0)
                begin
                    t_re       = 1'b1;
                    t_raddr    = AW'(lo_reg - IW'(1));
                    state_next = srpc_pkg::ST_UB_CHK;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_count_next = '0;
                    state_next     = srpc_pkg::ST_DONE;
                end
            end
            srpc_pkg::ST_UB_CMP:
            begin
                if (rd_value > qh_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + IW'(1);
                end
                state_next = srpc_pkg::ST_UB_STEP;
            end
            // lo_reg is one past the last entry; prefix difference gives the count
            srpc_pkg::ST_UB_CHK:
            begin
                res_found_next = (rd_value == qh_reg);
                res_count_next = '0;
                if ((rd_value == qh_reg) && (first_reg < lo_reg))
                begin
                    if (cnt_ext > SW'(srpc_pkg::COUNT_MAX))
                    begin
                        res_count_next = srpc_pkg::COUNT_MAX;
                    end
                    else
                    begin
                        res_count_next = cnt_ext[srpc_pkg::COUNT_BITS-1:0];
                    end
                end
                state_next = srpc_pkg::ST_DONE;
            end
            srpc_pkg::ST_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    of_next    = res_found_reg;
                    oc_next    = res_count_reg;
                    state_next = srpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srpc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= IW'(ENTRIES))
        else $error("entry count beyond table size");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tot_reg <= n_reg)
        else $error("prime total exceeds entry count");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !of_reg) |-> (oc_reg == '0))
        else $error("nonzero count on a miss");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.kind == srpc_pkg::KIND_CLEAR)) |=> (n_reg == '0))
        else $error("clear did not empty the table");

    a_no_accept_in_sieve: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srpc_pkg::ST_INIT || state_reg == srpc_pkg::ST_SV_MARK) |-> !req.ready)
        else $error("item taken while bitmap is built");
`endif

endmodule

// ----- dv/sorted_range_prime_counter_test.sv -----
`timescale 1ns / 100ps

module sorted_range_prime_counter_test;

    localparam int ENTRIES    = 1024;
    localparam int VALUE_BITS = 16;
    localparam int SPAN       = 1 << VALUE_BITS;

    typedef struct packed {
        logic                             found;
        logic [srpc_pkg::COUNT_BITS-1:0]  prime_count;
    } answer_t;

    logic clk;
    logic rst_n;

    srpc_req_if req ();
    srpc_rsp_if rsp ();

    sorted_range_prime_counter #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // shadow copy of the block state
    bit [VALUE_BITS-1:0] shadow_table [ENTRIES];
    int unsigned         shadow_count;
    bit                  is_prime [SPAN];

    // answers still owed by the block, oldest first
    answer_t     owed_answers [$];
    int unsigned mismatches;
    bit          hold_off;       // long receiver stall in progress
    bit          no_idle;        // stretch with no gaps on either side

    // sieve of eratosthenes over the whole value range
    function automatic void build_primes();
        int unsigned i;
        int unsigned j;
        for (i = 0; i < SPAN; i++)
            is_prime[i] = 1'b1;
        is_prime[0] = 1'b0;
        is_prime[1] = 1'b0;
        for (i = 2; i * i < SPAN; i++)
            if (is_prime[i])
                for (j = i * i; j < SPAN; j += i)
                    is_prime[j] = 1'b0;
    endfunction

    // smallest index with entry >= key (or > key when strict)
    function automatic int unsigned search_bound(bit [VALUE_BITS-1:0] key, bit strict);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit          go_left;
        lo = 0;
        hi = shadow_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            go_left = strict ? (shadow_table[mid] > key) : (shadow_table[mid] >= key);
            if (go_left)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    // update the shadow state for one item, queue the answer it owes
    function automatic void predict_item(srpc_pkg::kind_t kind, bit [15:0] value,
                                         bit [15:0] range_low, bit [15:0] range_high);
        int unsigned first;
        int unsigned ub;
        int unsigned count;
        int unsigned k;
        bit          ok_lo;
        bit          ok_hi;
        answer_t     ans;
        case (kind)
            srpc_pkg::KIND_LOAD:
                if (shadow_count < ENTRIES)
                begin
                    shadow_table[shadow_count] = value[VALUE_BITS-1:0];
                    shadow_count++;
                end
            srpc_pkg::KIND_CLEAR:
                shadow_count = 0;
            srpc_pkg::KIND_QUERY:
            begin
                first = search_bound(range_low[VALUE_BITS-1:0], 1'b0);
                ub    = search_bound(range_high[VALUE_BITS-1:0], 1'b1);
                ok_lo = (first < shadow_count) && (shadow_table[first] == range_low);
                ok_hi = (ub > 0) && (shadow_table[ub - 1] == range_high);
                count = 0;
                ans   = '0;
                if (ok_lo && ok_hi)
                begin
                    if (first <= ub - 1)
                        for (k = first; k <= ub - 1; k++)
                            if (is_prime[shadow_table[k]] && count < srpc_pkg::COUNT_MAX)
                                count++;
                    ans.found       = 1'b1;
                    ans.prime_count = count[srpc_pkg::COUNT_BITS-1:0];
                end
                owed_answers.push_back(ans);
            end
            default:
            begin
                // unused kind, ignored by the block
            end
        endcase
    endfunction

    // offer one item after a random gap, wait for acceptance
    task automatic send_item(srpc_pkg::kind_t kind, bit [15:0] value,
                             bit [15:0] range_low, bit [15:0] range_high);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.kind       <= kind;
        req.value      <= value;
        req.range_low  <= range_low;
        req.range_high <= range_high;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        // accepted at this edge, valid stays up for a following item
        predict_item(kind, value, range_low, range_high);
    endtask

    // receiver side: random stalls, plus the long hold-off
    initial
    begin
        int stall;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                rsp.ready <= 1'b0;
            else if (rsp.ready && rsp.valid)
            begin
                stall = no_idle ? 0 : $urandom_range(0, 17);
                if (stall > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (stall)
                        @(posedge clk);
                end
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // compare each accepted answer with the oldest owed one
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (owed_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer found=%0d count=%0d",
                             rsp.found, rsp.prime_count);
            end
            else
            begin
                want = owed_answers.pop_front();
                if (rsp.found !== want.found || rsp.prime_count !== want.prime_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected found=%0d count=%0d, got found=%0d count=%0d",
                                 want.found, want.prime_count, rsp.found, rsp.prime_count);
                end
            end
        end
    end

    // random value close to a small set so queries hit often
    function automatic bit [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    // load a sorted set of n values, return them through the shadow
    task automatic load_sorted(int n, int step_max);
        bit [15:0] v;
        int        i;
        v = 16'($urandom_range(0, 30));
        for (i = 0; i < n; i++)
        begin
            send_item(srpc_pkg::KIND_LOAD, v, 16'($urandom), 16'($urandom));
            if (int'(v) + step_max <= 16'hFFFF)
                v = v + 16'($urandom_range(0, step_max));
        end
    endtask

    // query with bounds taken from the table most of the time
    task automatic random_query();
        bit [15:0] lo;
        bit [15:0] hi;
        lo = pick_value();
        hi = pick_value();
        if (shadow_count > 0 && $urandom_range(0, 9) < 8)
        begin
            lo = shadow_table[$urandom_range(0, shadow_count - 1)];
            hi = shadow_table[$urandom_range(0, shadow_count - 1)];
        end
        send_item(srpc_pkg::KIND_QUERY, 16'($urandom), lo, hi);
    endtask

    // extremes, every kind and the special cases
    task automatic test_directed();
        send_item(srpc_pkg::KIND_QUERY, 16'hFFFF, 16'd0, 16'hFFFF);     // empty table
        send_item(srpc_pkg::KIND_NONE, 16'd5, 16'd5, 16'd5);            // unused kind
        send_item(srpc_pkg::KIND_LOAD, 16'd0, 16'hFFFF, 16'hFFFF);
        send_item(srpc_pkg::KIND_LOAD, 16'd2, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_LOAD, 16'd2, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_LOAD, 16'd3, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_LOAD, 16'd4, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_LOAD, 16'd65521, 16'd0, 16'd0);        // largest prime
        send_item(srpc_pkg::KIND_LOAD, 16'hFFFF, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd0, 16'hFFFF);        // whole table
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd2, 16'd2);           // duplicates
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd4, 16'd2);           // reversed range
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd1, 16'd3);           // low missing
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd3, 16'd5);           // high missing
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd65521, 16'd65521);
        send_item(srpc_pkg::KIND_CLEAR, 16'd0, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd0, 16'd0);           // cleared
        // unsorted table
        send_item(srpc_pkg::KIND_LOAD, 16'd7, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_LOAD, 16'd3, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_LOAD, 16'd11, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_LOAD, 16'd5, 16'd0, 16'd0);
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd3, 16'd11);
        send_item(srpc_pkg::KIND_QUERY, 16'd0, 16'd7, 16'd5);
        send_item(srpc_pkg::KIND_CLEAR, 16'd0, 16'd0, 16'd0);
    endtask

    // fill the table past full, dropped loads, whole-table count
    task automatic test_full_table();
        load_sorted(ENTRIES + 3, 3);
        send_item(srpc_pkg::KIND_QUERY, 16'd0, shadow_table[0], shadow_table[ENTRIES - 1]);
        random_query();
        random_query();
        send_item(srpc_pkg::KIND_CLEAR, 16'd0, 16'd0, 16'd0);
    endtask

    // sorted sets with random queries, some noise mixed in
    task automatic test_random();
        int sets;
        int i;
        for (sets = 0; sets < 25; sets++)
        begin
            no_idle = (sets % 6 == 5);
            load_sorted($urandom_range(1, 12), $urandom_range(0, 4) == 0 ? 2000 : 3);
            for (i = 0; i < 7; i++)
                case ($urandom_range(0, 9))
                    0:       send_item(srpc_pkg::KIND_LOAD, pick_value(),
                                       16'($urandom), 16'($urandom));
                    1:       send_item(srpc_pkg::KIND_NONE, 16'($urandom),
                                       16'($urandom), 16'($urandom));
                    default: random_query();
                endcase
            send_item(srpc_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        no_idle = 1'b0;
    endtask

    // receiver stops for a long time while queries keep coming
    task automatic test_backpressure();
        int i;
        load_sorted(6, 3);
        fork
            begin
                hold_off = 1'b1;
                repeat (400)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            for (i = 0; i < 12; i++)
                random_query();
        join
        send_item(srpc_pkg::KIND_CLEAR, 16'd0, 16'd0, 16'd0);
    endtask

    initial
    begin
        int settle;
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.kind       <= srpc_pkg::KIND_NONE;
        req.value      <= '0;
        req.range_low  <= '0;
        req.range_high <= '0;
        mismatches     = 0;
        hold_off       = 1'b0;
        no_idle        = 1'b0;
        shadow_count   = 0;
        build_primes();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        test_full_table();
        req.valid <= 1'b0;

        // drain, then let the last query finish
        settle = 0;
        while (owed_answers.size() != 0 && settle < 200000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (200)
            @(posedge clk);
        if (mismatches == 0 && owed_answers.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // timeout guard; the sieve and the whole run stay well under this limit
    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sorted_range_prime_counter.f -----
design/srpc_pkg.sv
design/srpc_if.sv
design/sorted_range_prime_counter.sv
dv/sorted_range_prime_counter_test.sv
